[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the usual clk / arst_n pair
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[design/imucf_pkg.sv]
// ----------------------------------------------------------------------------
// IMU calibrate/filter package
// Types, constants and saturation helpers shared by the block.
// ----------------------------------------------------------------------------
package imucf_pkg;

	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 16;
	localparam int VALUE_W     = 32;
	localparam int GAIN_W      = 24;
	localparam int GAIN_FRAC   = 24;
	localparam int WEIGHT_W    = 16;
	localparam int WEIGHT_FRAC = 16;
	localparam int CH_W        = 3;
	localparam int POS_W       = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// shared multiplier: 33-bit signed by 24-bit signed
	localparam int MUL_A_W = VALUE_W + 1;
	localparam int MUL_B_W = GAIN_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [POS_W-1:0] BURST_LAST = POS_W'(13);
	localparam logic [2:0]       TEMP_WORD  = 3'd3;
	localparam int               NUM_CH     = 6;
	localparam logic [CH_W-1:0]  CH_GYRO_Z  = CH_W'(5);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_GAIN_X = 3'd0,
		REG_ACCEL_GAIN_Y = 3'd1,
		REG_ACCEL_GAIN_Z = 3'd2,
		REG_ACCEL_BIAS_X = 3'd3,
		REG_ACCEL_BIAS_Y = 3'd4,
		REG_ACCEL_BIAS_Z = 3'd5,
		REG_GYRO_GAIN    = 3'd6,
		REG_FILT_WEIGHTS = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE_MUL,
		ST_SCALE,
		ST_BIAS,
		ST_FILT_MUL,
		ST_FILT
	} state_t;

	// clamp a product-width value to 32-bit signed
	function automatic logic signed [VALUE_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[PROD_W-1:VALUE_W-1];
		hi_zeros = ~|v[PROD_W-1:VALUE_W-1];
		if (hi_ones || hi_zeros) begin
			return v[VALUE_W-1:0];
		end else if (v[PROD_W-1]) begin
			return {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(VALUE_W-1){1'b1}}};
		end
	endfunction

	// clamp a 33-bit difference to 32-bit signed
	function automatic logic signed [VALUE_W-1:0] sat_diff(input logic signed [VALUE_W:0] v);
		if (v[VALUE_W] == v[VALUE_W-1]) begin
			return v[VALUE_W-1:0];
		end else if (v[VALUE_W]) begin
			return {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(VALUE_W-1){1'b1}}};
		end
	endfunction

endpackage

[design/imucf_if.sv]
// ----------------------------------------------------------------------------
// IMU calibrate/filter channel interfaces
// Valid/ready channels for burst bytes in and filtered values out.
// ----------------------------------------------------------------------------
interface imucf_in_if;
	logic                           valid;
	logic                           ready;
	logic [imucf_pkg::BYTE_W-1:0]   data_byte;
	logic                           frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface imucf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [imucf_pkg::CH_W-1:0]           channel;
	logic signed [imucf_pkg::VALUE_W-1:0] filtered_value;
	logic                                 last_of_frame;

	modport source (output valid, output channel, output filtered_value,
		output last_of_frame, input ready);
	modport sink   (input valid, input channel, input filtered_value,
		input last_of_frame, output ready);
endinterface

[design/imucf_mul.sv]
// ----------------------------------------------------------------------------
// IMU calibrate/filter multiplier
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module imucf_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [imucf_pkg::MUL_A_W-1:0]  op_a,
	input  logic signed [imucf_pkg::MUL_B_W-1:0]  op_b,
	output logic signed [imucf_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= imucf_pkg::PROD_W'(op_a) * imucf_pkg::PROD_W'(op_b);
		end
	end

endmodule

[design/imu_sample_calibrate_filter_core.sv]
// High and temperature bytes are taken while idle and give no result. A low byte that
// completes an accel or gyro word steps through SCALE_MUL, SCALE, BIAS, FILT_MUL, FILT;
// FILT waits while the output is full and stalled, and leaving it loads the result and
// readies the block again. The shared multiplier is used twice per word (scale, filter).
// Reset (arst_n low, asynchronous) clears registers, byte position, latch and histories.
// ----------------------------------------------------------------------------
// IMU sample calibrate and filter core
// Assembles big-endian words from a 14-byte sensor burst, scales and
// calibrates them, and runs a per-channel first-order low-pass filter.
// ----------------------------------------------------------------------------
module imu_sample_calibrate_filter_core #(
	parameter int VALUE_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	imucf_in_if.sink                              in_ch,
	imucf_out_if.source                           out_ch,
	input  logic                                  cfg_we,
	input  logic [imucf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imucf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// gain has 24 fraction bits, result keeps VALUE_FRAC_BITS
	localparam int SHIFT = imucf_pkg::GAIN_FRAC - VALUE_FRAC_BITS;
	localparam logic signed [imucf_pkg::PROD_W-1:0] SCALE_RND =
		(imucf_pkg::PROD_W'(1) << SHIFT) >> 1;
	localparam logic signed [imucf_pkg::PROD_W-1:0] FILT_RND =
		imucf_pkg::PROD_W'(1) << (imucf_pkg::WEIGHT_FRAC - 1);

	// ---- configuration registers ----
	logic signed [imucf_pkg::GAIN_W-1:0]  accel_gain_q [3];
	logic signed [imucf_pkg::VALUE_W-1:0] accel_bias_q [3];
	logic signed [imucf_pkg::GAIN_W-1:0]  gyro_gain_q;
	logic [imucf_pkg::VALUE_W-1:0]        filter_weights_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_gain_q[0]  <= '0;
			accel_gain_q[1]  <= '0;
			accel_gain_q[2]  <= '0;
			accel_bias_q[0]  <= '0;
			accel_bias_q[1]  <= '0;
			accel_bias_q[2]  <= '0;
			gyro_gain_q      <= '0;
			filter_weights_q <= '0;
		end else if (cfg_we) begin
			case (imucf_pkg::cfg_reg_t'(cfg_index))
				imucf_pkg::REG_ACCEL_GAIN_X: accel_gain_q[0] <= cfg_data[imucf_pkg::GAIN_W-1:0];
				imucf_pkg::REG_ACCEL_GAIN_Y: accel_gain_q[1] <= cfg_data[imucf_pkg::GAIN_W-1:0];
				imucf_pkg::REG_ACCEL_GAIN_Z: accel_gain_q[2] <= cfg_data[imucf_pkg::GAIN_W-1:0];
				imucf_pkg::REG_ACCEL_BIAS_X: accel_bias_q[0] <= cfg_data;
				imucf_pkg::REG_ACCEL_BIAS_Y: accel_bias_q[1] <= cfg_data;
				imucf_pkg::REG_ACCEL_BIAS_Z: accel_bias_q[2] <= cfg_data;
				imucf_pkg::REG_GYRO_GAIN:    gyro_gain_q     <= cfg_data[imucf_pkg::GAIN_W-1:0];
				imucf_pkg::REG_FILT_WEIGHTS: filter_weights_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- sequencer ----
	imucf_pkg::state_t state_q, state_d;
	logic in_ready;
	logic mul_en;
	logic out_load;
	logic out_valid_q;

	// ---- byte assembly ----
	logic                                 in_acc;
	logic [imucf_pkg::POS_W-1:0]          byte_pos_q;
	logic [imucf_pkg::POS_W-1:0]          pos;
	logic [2:0]                           widx;
	logic                                 word_done;
	logic [imucf_pkg::BYTE_W-1:0]         high_byte_q;

	assign in_acc    = in_ch.valid & in_ready;
	assign pos       = in_ch.frame_start ? '0 : byte_pos_q;
	assign widx      = pos[imucf_pkg::POS_W-1:1];
	// low byte of a pair that is not the temperature word
	assign word_done = pos[0] & (widx != imucf_pkg::TEMP_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			high_byte_q <= '0;
		end else if (in_acc) begin
			// long bursts wrap and start over
			byte_pos_q <= (pos == imucf_pkg::BURST_LAST) ? '0 : pos + 1'b1;
			if (!pos[0]) begin
				high_byte_q <= in_ch.data_byte;
			end
		end
	end

	// ---- per-word payload ----
	logic signed [imucf_pkg::WORD_W-1:0]  word_q;
	logic [imucf_pkg::CH_W-1:0]           ch_q;
	logic                                 accel_q;
	logic signed [imucf_pkg::VALUE_W-1:0] scaled_q;
	logic signed [imucf_pkg::VALUE_W-1:0] x_q;

	always_ff @(posedge clk) begin
		if (in_acc && word_done) begin
			word_q  <= {high_byte_q, in_ch.data_byte};
			accel_q <= (widx < imucf_pkg::TEMP_WORD);
			// gyro words sit one slot later because of the temperature word
			ch_q    <= (widx < imucf_pkg::TEMP_WORD) ? widx : widx - 1'b1;
		end
	end

	// ---- channel history (six entries, reset to zero) ----
	logic signed [imucf_pkg::VALUE_W-1:0] hist_q [imucf_pkg::NUM_CH];
	logic signed [imucf_pkg::VALUE_W-1:0] hist_rd;
	assign hist_rd = hist_q[ch_q];

	// ---- operand selection ----
	logic signed [imucf_pkg::GAIN_W-1:0]  gain_sel;
	logic signed [imucf_pkg::VALUE_W-1:0] bias_sel;
	logic [imucf_pkg::WEIGHT_W-1:0]       weight_sel;

	always_comb begin
		case (ch_q)
			imucf_pkg::CH_W'(0): gain_sel = accel_gain_q[0];
			imucf_pkg::CH_W'(1): gain_sel = accel_gain_q[1];
			imucf_pkg::CH_W'(2): gain_sel = accel_gain_q[2];
			default:             gain_sel = gyro_gain_q;
		endcase
		case (ch_q)
			imucf_pkg::CH_W'(0): bias_sel = accel_bias_q[0];
			imucf_pkg::CH_W'(1): bias_sel = accel_bias_q[1];
			imucf_pkg::CH_W'(2): bias_sel = accel_bias_q[2];
			default:             bias_sel = '0; // gyro words carry no intercept
		endcase
		weight_sel = accel_q ? filter_weights_q[imucf_pkg::WEIGHT_W-1:0]
			: filter_weights_q[imucf_pkg::VALUE_W-1:imucf_pkg::WEIGHT_W];
	end

	// ---- shared multiplier ----
	// scale pass: word * gain
	// filter pass: a * (hist - x); y = (that + x * 2^16 + half) >> 16
	logic signed [imucf_pkg::MUL_A_W-1:0] mul_a;
	logic signed [imucf_pkg::MUL_B_W-1:0] mul_b;
	logic signed [imucf_pkg::PROD_W-1:0]  prod_q;

	always_comb begin
		if (state_q == imucf_pkg::ST_FILT_MUL) begin
			mul_a = imucf_pkg::MUL_A_W'(hist_rd) - imucf_pkg::MUL_A_W'(x_q);
			mul_b = imucf_pkg::MUL_B_W'({1'b0, weight_sel});
		end else begin
			mul_a = imucf_pkg::MUL_A_W'(word_q);
			mul_b = gain_sel;
		end
	end

	imucf_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// ---- post-multiply arithmetic ----
	logic signed [imucf_pkg::PROD_W-1:0]  scale_sum;
	logic signed [imucf_pkg::VALUE_W:0]   bias_diff;
	logic signed [imucf_pkg::PROD_W-1:0]  filt_sum;
	logic signed [imucf_pkg::VALUE_W-1:0] filt_y;

	assign scale_sum = (prod_q + SCALE_RND) >>> SHIFT;
	assign bias_diff = (imucf_pkg::VALUE_W+1)'(scaled_q) - (imucf_pkg::VALUE_W+1)'(bias_sel);
	assign filt_sum  = (prod_q + (imucf_pkg::PROD_W'(x_q) <<< imucf_pkg::WEIGHT_FRAC)
		+ FILT_RND) >>> imucf_pkg::WEIGHT_FRAC;
	assign filt_y    = imucf_pkg::sat_prod(filt_sum);

	always_ff @(posedge clk) begin
		if (state_q == imucf_pkg::ST_SCALE) begin
			scaled_q <= imucf_pkg::sat_prod(scale_sum);
		end
		if (state_q == imucf_pkg::ST_BIAS) begin
			x_q <= imucf_pkg::sat_diff(bias_diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < imucf_pkg::NUM_CH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (out_load) begin
			hist_q[ch_q] <= filt_y;
		end
	end

	// ---- state register, next state, outputs ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imucf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			imucf_pkg::ST_IDLE: begin
				if (in_acc && word_done) begin
					state_d = imucf_pkg::ST_SCALE_MUL;
				end
			end
			imucf_pkg::ST_SCALE_MUL: state_d = imucf_pkg::ST_SCALE;
			imucf_pkg::ST_SCALE:     state_d = imucf_pkg::ST_BIAS;
			imucf_pkg::ST_BIAS:      state_d = imucf_pkg::ST_FILT_MUL;
			imucf_pkg::ST_FILT_MUL:  state_d = imucf_pkg::ST_FILT;
			imucf_pkg::ST_FILT: begin
				if (out_load) begin
					state_d = imucf_pkg::ST_IDLE;
				end
			end
			default: state_d = imucf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mul_en   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			imucf_pkg::ST_IDLE:      in_ready = 1'b1;
			imucf_pkg::ST_SCALE_MUL: mul_en   = 1'b1;
			imucf_pkg::ST_FILT_MUL:  mul_en   = 1'b1;
			// hold the finished value until the output register is free
			imucf_pkg::ST_FILT:      out_load = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	assign in_ch.ready = in_ready;

	// ---- output register ----
	logic [imucf_pkg::CH_W-1:0]           out_channel_q;
	logic signed [imucf_pkg::VALUE_W-1:0] out_value_q;
	logic                                 out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_channel_q <= ch_q;
			out_value_q   <= filt_y;
			out_last_q    <= (ch_q == imucf_pkg::CH_GYRO_Z);
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.channel        = out_channel_q;
	assign out_ch.filtered_value = out_value_q;
	assign out_ch.last_of_frame  = out_last_q;

endmodule

[design/imucf_checker.sv]
// ----------------------------------------------------------------------------
// IMU calibrate/filter checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imucf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [imucf_pkg::CH_W-1:0]      channel,
	input logic [imucf_pkg::VALUE_W-1:0]   filtered_value,
	input logic                            last_of_frame
);

	// a stalled result transaction holds its channel and value
	`ASSERT_STD(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(filtered_value), "output changed while stalled")

	// end-of-burst flag only on gyro z
	`ASSERT_STD(a_last_gz, out_valid |-> (last_of_frame == (channel == imucf_pkg::CH_GYRO_Z)), "last_of_frame mismatch")

	// only six channels exist
	`ASSERT_STD(a_ch_range, out_valid |-> (channel < imucf_pkg::CH_W'(imucf_pkg::NUM_CH)), "channel out of range")

	// the core only goes busy after taking a byte
	`ASSERT_STD(a_busy_cause, $fell(in_ready) |-> $past(in_valid), "ready dropped without a transaction")

endmodule

bind imu_sample_calibrate_filter_core imucf_checker u_imucf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.channel        (out_ch.channel),
	.filtered_value (out_ch.filtered_value),
	.last_of_frame  (out_ch.last_of_frame)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// IMU calibrate/filter core testbench
// Feeds sensor bursts one byte per transaction under random source gaps and
// sink stalls, predicts every filtered value in the bench, and checks each
// result in order against that prediction over several calibration settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FRAC_BITS  = 16;
	localparam int NUM_REGS   = 1 << imucf_pkg::CFG_IDX_W;
	localparam int BURST_LEN  = int'(imucf_pkg::BURST_LAST) + 1;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 60;
	// settling time once the last result is in: a lone high byte may still be in flight
	localparam int SETTLE_CYCLES = 12;

	// calibration plan styles
	localparam int PLAN_MIXED = 0;
	localparam int PLAN_HIGH  = 1;
	localparam int PLAN_LOW   = 2;

	typedef struct packed {
		logic [imucf_pkg::BYTE_W-1:0] data_byte;
		logic                         frame_start;
	} burst_byte_t;

	typedef struct packed {
		logic [imucf_pkg::CH_W-1:0]           channel;
		logic signed [imucf_pkg::VALUE_W-1:0] filtered_value;
		logic                                 last_of_frame;
	} filt_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                             cfg_we;
	logic [imucf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [imucf_pkg::CFG_DATA_W-1:0] cfg_data;

	imucf_in_if  byte_bus ();
	imucf_out_if value_bus ();

	imu_sample_calibrate_filter_core #(
		.VALUE_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (byte_bus),
		.out_ch   (value_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Bench copy of the block: calibration registers, burst position, high
	// byte latch and per-channel filter history.
	// ------------------------------------------------------------------------
	longint          acc_gain [3];
	longint          acc_bias [3];
	longint          gyr_gain;
	logic [31:0]     filt_weights;
	logic [imucf_pkg::POS_W-1:0]  burst_pos;
	logic [imucf_pkg::BYTE_W-1:0] hi_latch;
	longint          hist [imucf_pkg::NUM_CH];

	logic [31:0]  reg_plan [NUM_REGS];
	burst_byte_t  pending_bytes [$];
	filt_result_t expected_vals [$];

	// handshake flags, set at the rising edge and read by the drivers at the falling edge
	bit byte_taken;
	bit value_taken;
	bit src_idle;
	bit sink_idle;
	int src_wait;
	int sink_wait;

	int error_count;
	int n_bytes;
	int n_values;
	int n_bursts;
	int n_noise;
	int n_settings;

	function automatic longint clamp_q32(input longint v);
		if (v > longint'(32'sh7FFFFFFF))
			return longint'(32'sh7FFFFFFF);
		if (v < -longint'(32'sh7FFFFFFF) - 1)
			return -longint'(32'sh7FFFFFFF) - 1;
		return v;
	endfunction

	// raw word times gain, rounded half up from 24 to FRAC_BITS fraction bits
	function automatic longint scale_raw_word(input longint word, input longint gain);
		longint p;
		int     sh;
		sh = imucf_pkg::GAIN_FRAC - FRAC_BITS;
		p = word * gain;
		if (sh > 0)
			p = (p + (longint'(1) << (sh - 1))) >>> sh;
		return clamp_q32(p);
	endfunction

	function automatic void apply_setting(input imucf_pkg::cfg_reg_t idx,
		input logic [31:0] v);
		case (idx)
			imucf_pkg::REG_ACCEL_GAIN_X:
				acc_gain[0] = longint'($signed(v[imucf_pkg::GAIN_W-1:0]));
			imucf_pkg::REG_ACCEL_GAIN_Y:
				acc_gain[1] = longint'($signed(v[imucf_pkg::GAIN_W-1:0]));
			imucf_pkg::REG_ACCEL_GAIN_Z:
				acc_gain[2] = longint'($signed(v[imucf_pkg::GAIN_W-1:0]));
			imucf_pkg::REG_ACCEL_BIAS_X: acc_bias[0] = longint'($signed(v));
			imucf_pkg::REG_ACCEL_BIAS_Y: acc_bias[1] = longint'($signed(v));
			imucf_pkg::REG_ACCEL_BIAS_Z: acc_bias[2] = longint'($signed(v));
			imucf_pkg::REG_GYRO_GAIN:
				gyr_gain = longint'($signed(v[imucf_pkg::GAIN_W-1:0]));
			imucf_pkg::REG_FILT_WEIGHTS: filt_weights = v;
			default: ;
		endcase
	endfunction

	// one accepted byte: advance the burst position and, on the low byte of an
	// accel or gyro word, work out the filtered value it produces
	function automatic void predict_filtered(input logic [imucf_pkg::BYTE_W-1:0] b,
		input logic fs);
		logic [imucf_pkg::POS_W-1:0] pos;
		logic [2:0]                  widx;
		logic [imucf_pkg::CH_W-1:0]  ch;
		longint           word;
		longint           x;
		longint           y;
		longint           a;
		filt_result_t     r;
		if (fs)
			burst_pos = '0;
		pos = burst_pos;
		burst_pos = (pos == imucf_pkg::BURST_LAST) ? '0 : pos + 1'b1;
		if (!pos[0]) begin
			hi_latch = b;
			return;
		end
		widx = pos[3:1];
		if (widx == imucf_pkg::TEMP_WORD)
			return;
		word = longint'($signed({hi_latch, b}));
		if (widx < imucf_pkg::TEMP_WORD) begin
			ch = imucf_pkg::CH_W'(widx);
			x = clamp_q32(scale_raw_word(word, acc_gain[ch]) - acc_bias[ch]);
			a = longint'(filt_weights[imucf_pkg::WEIGHT_W-1:0]);
		end else begin
			ch = imucf_pkg::CH_W'(widx - 1'b1);
			x = scale_raw_word(word, gyr_gain);
			a = longint'(filt_weights[31:imucf_pkg::WEIGHT_W]);
		end
		y = clamp_q32((a * hist[ch] + ((longint'(1) << imucf_pkg::WEIGHT_FRAC) - a) * x
			+ (longint'(1) << (imucf_pkg::WEIGHT_FRAC - 1))) >>> imucf_pkg::WEIGHT_FRAC);
		hist[ch] = y;
		r.channel        = ch;
		r.filtered_value = imucf_pkg::VALUE_W'(y);
		r.last_of_frame  = (ch == imucf_pkg::CH_GYRO_Z);
		expected_vals.push_back(r);
	endfunction

	function automatic void note_miss(input string what);
		error_count++;
		if (error_count <= 10)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endfunction

	function automatic int draw_gap(input bit idle_on);
		return idle_on ? $urandom_range(0, 14) : 0;
	endfunction

	// ------------------------------------------------------------------------
	// Byte driver: one transaction per queued byte, with a random gap drawn
	// after each. valid holds until the block takes the byte.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive_bytes
		burst_byte_t nxt;
		if (!arst_n) begin
			byte_bus.valid <= 1'b0;
		end else if (byte_bus.valid && !byte_taken) begin
			// still waiting on ready, keep everything as it is
		end else if (src_wait > 0) begin
			byte_bus.valid <= 1'b0;
			src_wait--;
		end else if (pending_bytes.size() > 0) begin
			nxt = pending_bytes.pop_front();
			byte_bus.valid       <= 1'b1;
			byte_bus.data_byte   <= nxt.data_byte;
			byte_bus.frame_start <= nxt.frame_start;
			src_wait = draw_gap(src_idle);
		end else begin
			byte_bus.valid <= 1'b0;
		end
	end

	// Result sink: after every taken result, stall ready for a drawn number of cycles
	always @(negedge clk) begin
		if (!arst_n) begin
			value_bus.ready <= 1'b0;
		end else begin
			if (value_taken)
				sink_wait = draw_gap(sink_idle);
			if (sink_wait > 0) begin
				value_bus.ready <= 1'b0;
				sink_wait--;
			end else begin
				value_bus.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: inputs are predicted as they are accepted, results are checked
	// in order against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		filt_result_t want;
		if (arst_n) begin
			byte_taken = byte_bus.valid && byte_bus.ready;
			if (byte_taken) begin
				n_bytes++;
				predict_filtered(byte_bus.data_byte, byte_bus.frame_start);
			end
			value_taken = value_bus.valid && value_bus.ready;
			if (value_taken) begin
				n_values++;
				if (expected_vals.size() == 0) begin
					note_miss($sformatf("result with nothing pending: ch %0d value %0d last %0b",
						value_bus.channel, value_bus.filtered_value, value_bus.last_of_frame));
				end else begin
					want = expected_vals.pop_front();
					if (value_bus.channel !== want.channel
						|| value_bus.filtered_value !== want.filtered_value
						|| value_bus.last_of_frame !== want.last_of_frame) begin
						note_miss($sformatf(
							"expected ch %0d value %0d last %0b, got ch %0d value %0d last %0b",
							want.channel, want.filtered_value, want.last_of_frame,
							value_bus.channel, value_bus.filtered_value,
							value_bus.last_of_frame));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic void queue_byte(input logic [imucf_pkg::BYTE_W-1:0] b, input logic fs);
		burst_byte_t t;
		t.data_byte   = b;
		t.frame_start = fs;
		pending_bytes.push_back(t);
	endfunction

	// bytes lean towards the word extremes so saturation paths get hit
	function automatic logic [imucf_pkg::BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return imucf_pkg::BYTE_W'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_gain(input int style);
		logic [imucf_pkg::GAIN_W-1:0] g;
		if (style == PLAN_HIGH)
			g = {1'b0, {(imucf_pkg::GAIN_W-1){1'b1}}};
		else if (style == PLAN_LOW)
			g = {1'b1, {(imucf_pkg::GAIN_W-1){1'b0}}};
		else begin
			case ($urandom_range(0, 5))
				0: g = {1'b0, {(imucf_pkg::GAIN_W-1){1'b1}}};
				1: g = {1'b1, {(imucf_pkg::GAIN_W-1){1'b0}}};
				2: g = '0;
				default: g = imucf_pkg::GAIN_W'($urandom);
			endcase
		end
		return {{(32-imucf_pkg::GAIN_W){g[imucf_pkg::GAIN_W-1]}}, g};
	endfunction

	function automatic logic [31:0] pick_bias(input int style);
		if (style == PLAN_HIGH)
			return 32'h7FFF_FFFF;
		if (style == PLAN_LOW)
			return 32'h8000_0000;
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [imucf_pkg::WEIGHT_W-1:0] pick_weight(input int style);
		if (style == PLAN_HIGH)
			return '1;
		if (style == PLAN_LOW)
			return '0;
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			default: return imucf_pkg::WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic void plan_settings(input int style);
		reg_plan[imucf_pkg::REG_ACCEL_GAIN_X] = pick_gain(style);
		reg_plan[imucf_pkg::REG_ACCEL_GAIN_Y] = pick_gain(style);
		reg_plan[imucf_pkg::REG_ACCEL_GAIN_Z] = pick_gain(style);
		reg_plan[imucf_pkg::REG_ACCEL_BIAS_X] = pick_bias(style);
		reg_plan[imucf_pkg::REG_ACCEL_BIAS_Y] = pick_bias(style);
		reg_plan[imucf_pkg::REG_ACCEL_BIAS_Z] = pick_bias(style);
		reg_plan[imucf_pkg::REG_GYRO_GAIN]    = pick_gain(style);
		reg_plan[imucf_pkg::REG_FILT_WEIGHTS] = {pick_weight(style), pick_weight(style)};
	endfunction

	// write the whole plan, one register per cycle, block idle
	task automatic load_settings();
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= imucf_pkg::cfg_reg_t'(i);
			cfg_data  <= reg_plan[i];
			apply_setting(imucf_pkg::cfg_reg_t'(i), reg_plan[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// wait until every byte is taken and every result is back, then let any
	// byte that makes no result finish
	task automatic settle();
		while (pending_bytes.size() != 0 || byte_bus.valid)
			@(posedge clk);
		while (expected_vals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly clean bursts with random content; the rest cut-short bursts and
	// loose bytes with stray frame marks, which also run past the burst end
	task automatic fill_phase(input int target);
		int made;
		int len;
		made = 0;
		while (made < target) begin
			case ($urandom_range(0, 9))
				8: begin
					len = $urandom_range(1, BURST_LEN - 1);
					for (int i = 0; i < len; i++)
						queue_byte(pick_byte(), i == 0);
					n_noise++;
				end
				9: begin
					len = $urandom_range(1, 20);
					for (int i = 0; i < len; i++)
						queue_byte(pick_byte(), $urandom_range(0, 7) == 0);
					n_noise++;
				end
				default: begin
					len = BURST_LEN;
					for (int i = 0; i < len; i++)
						queue_byte(pick_byte(), i == 0);
					n_bursts++;
				end
			endcase
			made += len;
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		byte_bus.valid       = 1'b0;
		byte_bus.data_byte   = '0;
		byte_bus.frame_start = 1'b0;
		value_bus.ready      = 1'b0;
		burst_pos            = '0;
		hi_latch             = '0;
		filt_weights         = '0;
		gyr_gain             = 0;
		for (int i = 0; i < 3; i++) begin
			acc_gain[i] = 0;
			acc_bias[i] = 0;
		end
		for (int i = 0; i < imucf_pkg::NUM_CH; i++)
			hist[i] = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: largest gains of both signs, biases at both ends so the
		// subtraction saturates, no accel smoothing and heavy gyro smoothing.
		reg_plan[imucf_pkg::REG_ACCEL_GAIN_X] = pick_gain(PLAN_HIGH);
		reg_plan[imucf_pkg::REG_ACCEL_GAIN_Y] = pick_gain(PLAN_LOW);
		reg_plan[imucf_pkg::REG_ACCEL_GAIN_Z] = pick_gain(PLAN_MIXED);
		reg_plan[imucf_pkg::REG_ACCEL_BIAS_X] = pick_bias(PLAN_LOW);
		reg_plan[imucf_pkg::REG_ACCEL_BIAS_Y] = pick_bias(PLAN_HIGH);
		reg_plan[imucf_pkg::REG_ACCEL_BIAS_Z] = '0;
		reg_plan[imucf_pkg::REG_GYRO_GAIN]    = pick_gain(PLAN_LOW);
		reg_plan[imucf_pkg::REG_FILT_WEIGHTS] = {16'hFFFF, 16'h0000};
		load_settings();
		src_idle  = $urandom_range(0, 1);
		sink_idle = $urandom_range(0, 1);

		// full burst: word extremes and values near zero, temperature in the middle
		queue_byte(8'h7F, 1'b1); queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0); queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
		queue_byte(8'h12, 1'b0); queue_byte(8'h34, 1'b0);
		queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0); queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0); queue_byte(8'hFF, 1'b0);
		// overlong burst: wraps into a new one, then stops halfway through a word
		queue_byte(8'h01, 1'b0); queue_byte(8'h02, 1'b0);
		queue_byte(8'hAB, 1'b0);
		// frame start in mid-burst drops the half word
		queue_byte(8'h80, 1'b1); queue_byte(8'h01, 1'b0);
		queue_byte(8'hFF, 1'b0); queue_byte(8'h80, 1'b0);
		settle();

		// Random phases: first all registers at the top, then at the bottom,
		// then mixed settings
		for (int p = 1; p <= NUM_PHASES; p++) begin
			plan_settings(p == 1 ? PLAN_HIGH : (p == 2 ? PLAN_LOW : PLAN_MIXED));
			load_settings();
			src_idle  = $urandom_range(0, 3) != 0;
			sink_idle = $urandom_range(0, 3) != 0;
			fill_phase(PHASE_ITEMS);
			settle();
		end

		// last results plus a short tail for anything unexpected
		for (int k = 0; k < 4000 && expected_vals.size() != 0; k++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_vals.size() != 0)
			note_miss($sformatf("%0d results never arrived", expected_vals.size()));

		$display("Run covered %0d byte transactions and %0d filtered values over %0d settings.",
			n_bytes, n_values, n_settings);
		$display("Stimulus held %0d clean bursts and %0d broken runs; %0d mismatches.",
			n_bursts, n_noise, error_count);
		if (error_count == 0) begin
			$display("imu_sample_calibrate_filter_core test passed");
		end else begin
			$display("imu_sample_calibrate_filter_core test failed");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#1_000_000;
		$display("imu_sample_calibrate_filter_core test failed");
		$finish;
	end

endmodule
